// ===== rtl/peer_wire_stream_deframer_macros.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef PEER_WIRE_STREAM_DEFRAMER_MACROS_SVH
`define PEER_WIRE_STREAM_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define PWSD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Antecedent implies consequent in the next cycle.
`define PWSD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PWSD_ASSERT_IMP(label, ante, cons, msg)
`define PWSD_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/pwsd_pkg.sv =====
package pwsd_pkg;

  // Handshake layout
  localparam int HS_BYTES      = 68;
  localparam int PEER_ID_BYTES = 20;
  localparam int PEER_ID_FIRST = 48;
  localparam int NAME_FIRST    = 1;
  localparam int NAME_LEN      = 19;

  // Protocol name, first character in the top byte
  localparam logic [8*NAME_LEN-1:0] PROTO_NAME = "BitTorrent protocol";

  // Reset value of the extended message id register
  localparam logic [7:0] EXT_MSG_ID_RESET = 8'd20;

  // Result kinds as carried on tuser
  typedef enum logic [2:0] {
    KIND_PEER_ID   = 3'd0,
    KIND_EXT_HDR   = 3'd1,
    KIND_EXT_DATA  = 3'd2,
    KIND_SIZE_ERR  = 3'd3,
    KIND_MISMATCH  = 3'd4,
    KIND_DROPPED   = 3'd5
  } kind_e;

  // One result beat between the parser and the output register
  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] ext_id;
    logic       last;
  } pwsd_result_t;

  // Expected protocol name character at position idx (0 .. NAME_LEN-1)
  function automatic logic [7:0] proto_char(input logic [4:0] idx);
    logic [7:0] ch;
    ch = PROTO_NAME[8*(NAME_LEN-1-int'(idx)) +: 8];
    return ch;
  endfunction

endpackage

// ===== rtl/peer_wire_stream_deframer.sv =====
// Peer wire stream deframer.
// The slave stream carries the received connection bytes, one byte a beat.
// The first 68 bytes are the handshake: bytes 1 to 19 are checked against
// the protocol name, bytes 48 to 67 leave as peer id beats (tlast on the
// final one). A name mismatch gives one report beat, after which every
// byte is swallowed until reset. Then length-prefixed frames follow:
// extended frames leave as a header beat and payload beats, tlast on the
// final beat, or as one size error beat at length 1; other frames and
// keep-alives give one drop beat. The configuration channel writes the
// extended message id (reset 20); write it only while no byte is in flight.
// A result leaves through the input register and then the result register.
// Throughput: one byte per cycle while the master side takes results, set
// by the single parser step between the two registers.
// After reset the block waits for the handshake with empty registers.
// When the master side stalls, the result is held and one more byte is
// taken into the input register, then tready drops until the result goes.
`include "peer_wire_stream_deframer_macros.svh"
module peer_wire_stream_deframer
  import pwsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,      // extended_msg_id
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,    // [7:0] data, [15:8] ext_id
  output logic [2:0]  m_axis_tuser,    // [2:0] kind
  output logic        m_axis_tlast     // last
);

  logic         in_valid;
  logic [7:0]   in_data;
  logic         out_free;
  logic         advance;
  pwsd_result_t res;

  assign cfg_ready_o = 1'b1;

  // Consume the held byte when the result register can take its outcome
  assign advance = in_valid && out_free;

  pwsd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tdata_i  (s_axis_tdata),
    .s_tready_o (s_axis_tready),
    .take_i     (advance),
    .valid_o    (in_valid),
    .data_o     (in_data)
  );

  pwsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (advance),
    .byte_i      (in_data),
    .res_o       (res)
  );

  pwsd_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .res_i      (res),
    .free_o     (out_free),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

  // Nothing follows a delivered handshake mismatch report
  `PWSD_ASSERT_NXT(a_dead_after_mismatch,
    m_axis_tvalid && m_axis_tready && (m_axis_tuser == KIND_MISMATCH),
    !m_axis_tvalid, "output after handshake mismatch")

  // The final peer id beat is not followed by another peer id beat
  `PWSD_ASSERT_NXT(a_peer_id_ends,
    m_axis_tvalid && m_axis_tready && m_axis_tlast && (m_axis_tuser == KIND_PEER_ID),
    !(m_axis_tvalid && (m_axis_tuser == KIND_PEER_ID)), "peer id after its last beat")

  // A stalled result leaves room for exactly one buffered byte
  `PWSD_ASSERT_IMP(a_stall_buffer,
    m_axis_tvalid && !m_axis_tready && in_valid,
    !s_axis_tready, "byte taken past a full input register")

endmodule

// ===== rtl/pwsd_in_stage.sv =====
module pwsd_in_stage
  import pwsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  input  logic [7:0] s_tdata_i,
  output logic       s_tready_o,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] data_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;

  // Accept a new beat when empty or when the held one moves on this cycle
  assign s_tready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (s_tvalid_i && s_tready_o) begin
      valid_d = 1'b1;
      data_d  = s_tdata_i;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/pwsd_parser.sv =====
module pwsd_parser
  import pwsd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic [7:0]   cfg_data_i,
  input  logic         advance_i,
  input  logic [7:0]   byte_i,
  output pwsd_result_t res_o
);

  typedef enum logic [2:0] {
    PH_HANDSHAKE = 3'b001,
    PH_FRAMES    = 3'b010,
    PH_DEAD      = 3'b100
  } phase_e;

  typedef enum logic [7:0] {
    HDR_LEN0    = 8'b0000_0001,
    HDR_LEN1    = 8'b0000_0010,
    HDR_LEN2    = 8'b0000_0100,
    HDR_LEN3    = 8'b0000_1000,
    HDR_MSG_ID  = 8'b0001_0000,
    HDR_EXT_ID  = 8'b0010_0000,
    HDR_SKIP    = 8'b0100_0000,
    HDR_PAYLOAD = 8'b1000_0000
  } hdr_e;

  localparam logic [6:0] HS_LAST      = 7'(HS_BYTES - 1);
  localparam logic [6:0] NAME_LO      = 7'(NAME_FIRST);
  localparam logic [6:0] NAME_HI      = 7'(NAME_FIRST + NAME_LEN - 1);
  localparam logic [6:0] PEER_LO      = 7'(PEER_ID_FIRST);
  localparam logic [6:0] PEER_HI      = 7'(PEER_ID_FIRST + PEER_ID_BYTES - 1);

  phase_e      phase_q, phase_d;
  hdr_e        hdr_q, hdr_d;
  logic [6:0]  hs_cnt_q, hs_cnt_d;
  logic [31:0] len_q, len_d;
  logic [7:0]  ext_q, ext_d;
  logic [7:0]  ext_msg_id_q;

  logic        name_pos, peer_pos, hs_end;
  logic [4:0]  name_idx;
  logic [31:0] len_dec, len_new;
  logic        len_one;

  // Extended message id register; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_msg_id_q <= EXT_MSG_ID_RESET;
    end else if (cfg_valid_i) begin
      ext_msg_id_q <= cfg_data_i;
    end
  end

  assign name_pos = (hs_cnt_q >= NAME_LO) && (hs_cnt_q <= NAME_HI);
  assign peer_pos = (hs_cnt_q >= PEER_LO) && (hs_cnt_q <= PEER_HI);
  assign hs_end   = (hs_cnt_q == HS_LAST);
  assign name_idx = 5'(hs_cnt_q - NAME_LO);
  assign len_dec  = len_q - 32'd1;
  assign len_new  = {len_q[23:0], byte_i};
  assign len_one  = (len_q == 32'd1);

  // Decode one byte against the current phase and frame position
  always_comb begin
    phase_d      = phase_q;
    hdr_d        = hdr_q;
    hs_cnt_d     = hs_cnt_q;
    len_d        = len_q;
    ext_d        = ext_q;
    res_o        = '0;
    res_o.kind   = KIND_PEER_ID;
    case (phase_q)
      PH_HANDSHAKE: begin
        if (name_pos && (byte_i != proto_char(name_idx))) begin
          res_o.valid = 1'b1;
          res_o.kind  = KIND_MISMATCH;
          phase_d     = PH_DEAD;
        end else begin
          if (peer_pos) begin
            res_o.valid = 1'b1;
            res_o.kind  = KIND_PEER_ID;
            res_o.data  = byte_i;
            res_o.last  = hs_end;
          end
          if (hs_end) begin
            phase_d  = PH_FRAMES;
            hs_cnt_d = '0;
            hdr_d    = HDR_LEN0;
            len_d    = '0;
          end else begin
            hs_cnt_d = hs_cnt_q + 7'd1;
          end
        end
      end
      PH_FRAMES: begin
        case (hdr_q)
          HDR_LEN0: begin
            len_d = len_new;
            hdr_d = HDR_LEN1;
          end
          HDR_LEN1: begin
            len_d = len_new;
            hdr_d = HDR_LEN2;
          end
          HDR_LEN2: begin
            len_d = len_new;
            hdr_d = HDR_LEN3;
          end
          HDR_LEN3: begin
            len_d = len_new;
            if (len_new == 32'd0) begin
              // keep-alive
              res_o.valid = 1'b1;
              res_o.kind  = KIND_DROPPED;
              hdr_d       = HDR_LEN0;
            end else begin
              hdr_d = HDR_MSG_ID;
            end
          end
          HDR_MSG_ID: begin
            len_d = len_dec;
            if (byte_i == ext_msg_id_q) begin
              if (len_one) begin
                res_o.valid = 1'b1;
                res_o.kind  = KIND_SIZE_ERR;
                hdr_d       = HDR_LEN0;
              end else begin
                hdr_d = HDR_EXT_ID;
              end
            end else begin
              res_o.valid = 1'b1;
              res_o.kind  = KIND_DROPPED;
              res_o.data  = byte_i;
              hdr_d       = len_one ? HDR_LEN0 : HDR_SKIP;
            end
          end
          HDR_EXT_ID: begin
            len_d        = len_dec;
            ext_d        = byte_i;
            res_o.valid  = 1'b1;
            res_o.kind   = KIND_EXT_HDR;
            res_o.data   = byte_i;
            res_o.ext_id = byte_i;
            res_o.last   = len_one;
            hdr_d        = len_one ? HDR_LEN0 : HDR_PAYLOAD;
          end
          HDR_SKIP: begin
            len_d = len_dec;
            if (len_one) begin
              hdr_d = HDR_LEN0;
            end
          end
          HDR_PAYLOAD: begin
            len_d        = len_dec;
            res_o.valid  = 1'b1;
            res_o.kind   = KIND_EXT_DATA;
            res_o.data   = byte_i;
            res_o.ext_id = ext_q;
            res_o.last   = len_one;
            if (len_one) begin
              hdr_d = HDR_LEN0;
            end
          end
          default: begin
            hdr_d = HDR_LEN0;
          end
        endcase
      end
      default: begin
        // dead: ignore every byte until reset
      end
    endcase
  end

  // Advance parser state once per consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HANDSHAKE;
      hdr_q    <= HDR_LEN0;
      hs_cnt_q <= '0;
      len_q    <= '0;
      ext_q    <= '0;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      hdr_q    <= hdr_d;
      hs_cnt_q <= hs_cnt_d;
      len_q    <= len_d;
      ext_q    <= ext_d;
    end
  end

endmodule

// ===== rtl/pwsd_out_stage.sv =====
module pwsd_out_stage
  import pwsd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  pwsd_result_t res_i,
  output logic         free_o,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [15:0]  m_tdata_o,
  output logic [2:0]   m_tuser_o,
  output logic         m_tlast_o
);

  logic         valid_q, valid_d;
  pwsd_result_t res_q, res_d;

  // Room for a new result when empty or when the held beat leaves now
  assign free_o = !valid_q || m_tready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i && res_i.valid) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (m_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = {res_q.ext_id, res_q.data};
  assign m_tuser_o  = res_q.kind;
  assign m_tlast_o  = res_q.last;

endmodule

// ===== verif/tb_peer_wire_stream_deframer.sv =====
`timescale 1ns / 1ps
module tb_peer_wire_stream_deframer;
  import pwsd_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int PHASE_BYTES      = 230;
  localparam int BODY_CAP         = 100;
  localparam int HOLD_AFTER_BYTES = 700;
  localparam int HOLD_CYCLES      = 400;

  typedef enum logic [1:0] {
    LINK_HANDSHAKE,
    LINK_FRAMES,
    LINK_DEAD
  } link_phase_e;

  typedef enum logic [2:0] {
    FR_LEN0,
    FR_LEN1,
    FR_LEN2,
    FR_LEN3,
    FR_MSG_ID,
    FR_EXT_ID,
    FR_SKIP,
    FR_PAYLOAD
  } frame_pos_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] ext_id;
    logic       last;
  } deframe_beat_t;

  // Keep-alive, extended frame of length 1, extended frame with empty payload,
  // extended frame with payload, skipped frame with body
  localparam logic [7:0] DIRECTED_FRAMES [30] = '{
    8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h01, EXT_MSG_ID_RESET,
    8'h00, 8'h00, 8'h00, 8'h02, EXT_MSG_ID_RESET, 8'hAB,
    8'h00, 8'h00, 8'h00, 8'h04, EXT_MSG_ID_RESET, 8'h07, 8'h00, 8'hFF,
    8'h00, 8'h00, 8'h00, 8'h03, 8'hFF, 8'h01, 8'h02
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;    // [7:0] data_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // [7:0] data, [15:8] ext_id
  logic [2:0]  m_axis_tuser;          // [2:0] kind
  logic        m_axis_tlast;

  peer_wire_stream_deframer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Deframer state as the testbench tracks it
  logic [7:0]  ext_msg_id = EXT_MSG_ID_RESET;
  link_phase_e link_phase = LINK_HANDSHAKE;
  logic [6:0]  hs_count   = '0;
  frame_pos_e  frame_pos  = FR_LEN0;
  logic [31:0] frame_len  = '0;
  logic [31:0] bytes_left = '0;
  logic [7:0]  frame_ext  = '0;

  logic [7:0]    stream_q[$];
  deframe_beat_t beat_q[$];

  int bytes_offered = 0;
  int bytes_taken   = 0;
  int beats_seen    = 0;
  int beats_counted = 0;
  int cfg_writes    = 0;
  int errors        = 0;
  int cycle_count   = 0;
  int send_gap      = 0;
  int recv_gap      = 0;
  int hold_left     = 0;
  int kind_seen [6] = '{default: 0};
  bit send_burst    = 1'b0;
  bit recv_burst    = 1'b0;
  bit hold_done     = 1'b0;

  // Advance the tracked state by one stream byte and queue the beat it causes
  task automatic deframe_byte(input logic [7:0] b);
    int pos;
    pos = int'(hs_count);
    case (link_phase)
      LINK_HANDSHAKE: begin
        if (pos >= NAME_FIRST && pos < NAME_FIRST + NAME_LEN &&
            b != PROTO_NAME[8*(NAME_LEN-1-(pos-NAME_FIRST)) +: 8]) begin
          beat_q.push_back(deframe_beat_t'{KIND_MISMATCH, 8'h00, 8'h00, 1'b0});
          link_phase = LINK_DEAD;
        end else begin
          if (pos >= PEER_ID_FIRST && pos < PEER_ID_FIRST + PEER_ID_BYTES)
            beat_q.push_back(deframe_beat_t'{KIND_PEER_ID, b, 8'h00, pos == HS_BYTES - 1});
          if (pos + 1 >= HS_BYTES) begin
            link_phase = LINK_FRAMES;
            hs_count   = '0;
            frame_pos  = FR_LEN0;
            frame_len  = '0;
          end else begin
            hs_count = hs_count + 7'd1;
          end
        end
      end
      LINK_FRAMES: begin
        case (frame_pos)
          FR_LEN0, FR_LEN1, FR_LEN2: begin
            frame_len = {frame_len[23:0], b};
            frame_pos = frame_pos_e'(frame_pos + 3'd1);
          end
          FR_LEN3: begin
            frame_len  = {frame_len[23:0], b};
            bytes_left = frame_len;
            if (frame_len == 0) begin
              frame_pos = FR_LEN0;
              beat_q.push_back(deframe_beat_t'{KIND_DROPPED, 8'h00, 8'h00, 1'b0});
            end else begin
              frame_pos = FR_MSG_ID;
            end
          end
          FR_MSG_ID: begin
            bytes_left = bytes_left - 1;
            if (b == ext_msg_id) begin
              if (frame_len < 2) begin
                frame_pos = FR_LEN0;
                frame_len = '0;
                beat_q.push_back(deframe_beat_t'{KIND_SIZE_ERR, 8'h00, 8'h00, 1'b0});
              end else begin
                frame_pos = FR_EXT_ID;
              end
            end else begin
              frame_pos = (bytes_left == 0) ? FR_LEN0 : FR_SKIP;
              frame_len = '0;
              beat_q.push_back(deframe_beat_t'{KIND_DROPPED, b, 8'h00, 1'b0});
            end
          end
          FR_EXT_ID: begin
            frame_ext  = b;
            bytes_left = bytes_left - 1;
            frame_pos  = (bytes_left == 0) ? FR_LEN0 : FR_PAYLOAD;
            frame_len  = '0;
            beat_q.push_back(deframe_beat_t'{KIND_EXT_HDR, b, b, bytes_left == 0});
          end
          FR_SKIP: begin
            bytes_left = bytes_left - 1;
            if (bytes_left == 0) frame_pos = FR_LEN0;
          end
          default: begin
            bytes_left = bytes_left - 1;
            if (bytes_left == 0) frame_pos = FR_LEN0;
            beat_q.push_back(deframe_beat_t'{KIND_EXT_DATA, b, frame_ext, bytes_left == 0});
          end
        endcase
      end
      default: ;
    endcase
  endtask

  // Queue one frame; the body is cut short after BODY_CAP bytes
  task automatic queue_frame(input logic [7:0] ext_id_now, input logic [31:0] len);
    logic [7:0] id;
    id = ($urandom_range(0, 99) < 65) ? ext_id_now : 8'($urandom_range(0, 255));
    for (int i = 3; i >= 0; i--) stream_q.push_back(len[8*i +: 8]);
    if (len != 0) stream_q.push_back(id);
    for (int i = 1; i < len && i <= BODY_CAP; i++)
      stream_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic write_ext_id(input logic [7:0] value);
    int n;
    n = cfg_writes;
    @(negedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i); while (cfg_writes == n);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold until every byte is taken and every beat is back, then let the pipe settle
  task automatic wait_drained();
    while (stream_q.size() != 0 || bytes_taken != bytes_offered || beat_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Sample both sides: check result beats, track register writes and stream bytes
  always @(posedge clk_i) begin
    deframe_beat_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (beat_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat kind %0d data %h ext %h last %b", $time,
                   m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tlast);
        end else begin
          want = beat_q.pop_front();
          kind_seen[want.kind]++;
          if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.data ||
              m_axis_tdata[15:8] !== want.ext_id || m_axis_tlast !== want.last) begin
            errors++;
            $display("%0t: expected kind %0d data %h ext %h last %b, got kind %0d data %h ext %h last %b",
                     $time, want.kind, want.data, want.ext_id, want.last,
                     m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tlast);
          end
        end
        beats_seen++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        ext_msg_id = cfg_data_i;
        cfg_writes++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_byte(s_axis_tdata);
        bytes_taken++;
      end
    end
  end

  // Stream driver: present the next byte once the last one is taken, with random gaps
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || bytes_taken == bytes_offered) begin
        if (send_gap > 0) begin
          s_axis_tvalid <= 1'b0;
          send_gap--;
        end else if (stream_q.size() != 0) begin
          s_axis_tdata  <= stream_q.pop_front();
          s_axis_tvalid <= 1'b1;
          bytes_offered++;
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 14);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: stall at random per beat, and once hold off long enough to
  // back the block up into its input
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && bytes_taken >= HOLD_AFTER_BYTES) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (beats_counted != beats_seen) begin
        beats_counted = beats_seen;
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_gap = recv_burst ? 0 : $urandom_range(0, 14);
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (recv_gap > 0) begin
        m_axis_tready <= 1'b0;
        recv_gap--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [7:0]  phase_ext [8];
    logic [31:0] len;
    int          pick;

    phase_ext = '{8'h00, 8'hFF, 8'h00, 8'h00, EXT_MSG_ID_RESET, 8'h00, 8'h01, 8'h00};
    phase_ext[2] = 8'($urandom_range(0, 255));
    phase_ext[3] = 8'($urandom_range(0, 255));
    phase_ext[5] = 8'($urandom_range(0, 255));
    phase_ext[7] = 8'($urandom_range(0, 255));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // A name mismatch would silence the block until reset, and reset comes
    // only once, so the handshake is always well formed. Byte 0 and the
    // reserved bytes are unchecked and carry arbitrary values.
    stream_q.push_back(8'hFF);
    for (int i = 0; i < NAME_LEN; i++)
      stream_q.push_back(PROTO_NAME[8*(NAME_LEN-1-i) +: 8]);
    for (int i = NAME_FIRST + NAME_LEN; i < PEER_ID_FIRST; i++)
      stream_q.push_back(8'($urandom_range(0, 255)));
    stream_q.push_back(8'h00);
    stream_q.push_back(8'hFF);
    for (int i = 2; i < PEER_ID_BYTES; i++)
      stream_q.push_back(8'($urandom_range(0, 255)));
    foreach (DIRECTED_FRAMES[i]) stream_q.push_back(DIRECTED_FRAMES[i]);
    wait_drained();

    // Random frames, mostly short, under a new extended id for each phase
    foreach (phase_ext[p]) begin
      write_ext_id(phase_ext[p]);
      while (stream_q.size() < PHASE_BYTES) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) len = 0;
        else if (pick < 14) len = 1;
        else if (pick < 20) len = 2;
        else if (pick < 97) len = $urandom_range(3, 14);
        else len = $urandom_range(40, BODY_CAP);
        queue_frame(phase_ext[p], len);
      end
      wait_drained();
    end

    // Finish on a frame too long to ever complete
    len[31:24] = 8'($urandom_range(1, 255));
    len[23:0]  = 24'($urandom_range(0, 24'hFF_FFFF));
    queue_frame(phase_ext[7], len);
    wait_drained();
    repeat (10) @(negedge clk_i);

    $display("Streamed %0d bytes through a handshake and framed traffic, %0d id writes, %0d beats",
             bytes_taken, cfg_writes, beats_seen);
    $display("Beats: peer id %0d, ext header %0d, ext payload %0d, size error %0d, dropped %0d",
             kind_seen[KIND_PEER_ID], kind_seen[KIND_EXT_HDR], kind_seen[KIND_EXT_DATA],
             kind_seen[KIND_SIZE_ERR], kind_seen[KIND_DROPPED]);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
